/* sv/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/skvt_pkg.sv */
// types and constants for the symbol key value table
`timescale 1ns / 1ps

package skvt_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int NAME_CHARS   = 8;
  localparam int ADDRESS_BITS = 16;
  localparam int MAX_OUT      = 16;

  localparam int NAME_W     = 64;
  localparam int SYM_ADDR_W = 16;
  localparam int KEY_BITS   = 8 * NAME_CHARS;
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_W     = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_DISPLAY = 3'd2,
    CMD_SEARCH  = 3'd3,
    CMD_MODIFY  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    STS_INSERTED  = 4'd0,
    STS_DUPLICATE = 4'd1,
    STS_DELETED   = 4'd2,
    STS_NOT_FOUND = 4'd3,
    STS_FOUND     = 4'd4,
    STS_MODIFIED  = 4'd5,
    STS_FULL      = 4'd6,
    STS_ENTRY     = 4'd7,
    STS_EMPTY     = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]            command;
    logic [NAME_W-1:0]     sym_name;
    logic [SYM_ADDR_W-1:0] sym_address;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [NAME_W-1:0]     out_name;
    logic [SYM_ADDR_W-1:0] out_address;
    logic                  last;
  } rsp_t;

endpackage

/* sv/skvt_ram.sv */
// single-port-write, registered-read memory used for keys and addresses
`timescale 1ns / 1ps

module skvt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_idx,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IW-1:0]    rd_idx,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

/* sv/symbol_key_value_table.sv */
// symbol table: every known command scans all slots, one memory read per cycle
// display: one full scan of the key memory per listed entry
// one command at a time: a new one is taken only in idle, once the last result is registered;
// the scan of the key memory sets the pace. Results wait in an output register while the next
// command is taken
// reset: valid bits and fill count clear at once; key and address memories are not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module symbol_key_value_table
  import skvt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;

  // latched command
  logic [2:0]              cmd_q;
  logic [NAME_W-1:0]       name_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [ADDRESS_BITS-1:0] addr_q;

  logic [TABLE_DEPTH-1:0]  slot_valid;
  logic [SCAN_W-1:0]       fill_cnt;

  // scan pipeline
  logic [SCAN_W-1:0] scan_cnt;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic              scan_done;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic [KEY_BITS-1:0]     rd_key;
  logic [ADDRESS_BITS-1:0] rd_addr;

  // scan results
  logic                    hit_fnd;
  logic [IDX_W-1:0]        hit_idx;
  logic [ADDRESS_BITS-1:0] hit_addr;
  logic                    free_fnd;
  logic [IDX_W-1:0]        free_idx;
  logic                    best_fnd;
  logic [KEY_BITS-1:0]     best_key;
  logic [ADDRESS_BITS-1:0] best_addr;
  logic                    have_prev;
  logic [KEY_BITS-1:0]     prev_key;
  logic [OUT_CNT_W-1:0]    disp_cnt;
  logic [OUT_CNT_W-1:0]    disp_total;

  // control from the state machine
  logic             emit;
  rsp_t             rsp_next;
  logic             key_we;
  logic             addr_we;
  logic [IDX_W-1:0] wr_idx;
  logic             set_valid;
  logic             clr_valid;
  logic             restart;
  logic             can_emit;
  logic             cmd_known;
  logic             elem_valid;

  assign rd_en     = (state == S_SCAN) && (int'(scan_cnt) < TABLE_DEPTH);
  assign rd_idx    = scan_cnt[IDX_W-1:0];
  assign scan_done = (int'(scan_cnt) == TABLE_DEPTH);
  assign can_emit  = !rsp_valid || rsp_ready;
  assign elem_valid = slot_valid[cmp_idx];

  assign disp_total = (int'(fill_cnt) >= MAX_OUT) ? OUT_CNT_W'(MAX_OUT)
                                                  : OUT_CNT_W'(fill_cnt);

  assign cmd_known = (req.command == CMD_INSERT) || (req.command == CMD_DELETE) ||
                     (req.command == CMD_DISPLAY) || (req.command == CMD_SEARCH) ||
                     (req.command == CMD_MODIFY);

  skvt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_idx  (wr_idx),
    .wr_data (key_q),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_key)
  );

  skvt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ADDRESS_BITS)
  ) u_addr_ram (
    .clk     (clk),
    .wr_en   (addr_we),
    .wr_idx  (wr_idx),
    .wr_data (addr_q),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = (state == S_IDLE);
    emit        = 1'b0;
    key_we      = 1'b0;
    addr_we     = 1'b0;
    wr_idx      = hit_idx;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    restart     = 1'b0;
    rsp_next.status      = STS_NOT_FOUND;
    rsp_next.out_name    = name_q;
    rsp_next.out_address = '0;
    rsp_next.last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        // unknown commands are taken and dropped
        if (req_valid && cmd_known) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          unique case (cmd_q)
            CMD_INSERT: begin
              if (hit_fnd) begin
                rsp_next.status = STS_DUPLICATE;
              end else if (free_fnd) begin
                rsp_next.status = STS_INSERTED;
                wr_idx    = free_idx;
                key_we    = 1'b1;
                addr_we   = 1'b1;
                set_valid = 1'b1;
              end else begin
                rsp_next.status = STS_FULL;
              end
            end
            CMD_DELETE: begin
              if (hit_fnd) begin
                rsp_next.status = STS_DELETED;
                clr_valid = 1'b1;
              end
            end
            CMD_SEARCH: begin
              if (hit_fnd) begin
                rsp_next.status      = STS_FOUND;
                rsp_next.out_address = SYM_ADDR_W'(hit_addr);
              end
            end
            CMD_MODIFY: begin
              if (hit_fnd) begin
                rsp_next.status = STS_MODIFIED;
                addr_we = 1'b1;
              end
            end
            CMD_DISPLAY: begin
              if (best_fnd) begin
                rsp_next.status      = STS_ENTRY;
                rsp_next.out_name    = NAME_W'(best_key) << (NAME_W - KEY_BITS);
                rsp_next.out_address = SYM_ADDR_W'(best_addr);
                rsp_next.last        = ((disp_cnt + OUT_CNT_W'(1)) == disp_total);
                if (!rsp_next.last) begin
                  state_next = S_SCAN;
                  restart    = 1'b1;
                end
              end else begin
                rsp_next.status   = STS_EMPTY;
                rsp_next.out_name = '0;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      fill_cnt   <= '0;
      slot_valid <= '0;
      cmp_vld    <= 1'b0;
      hit_fnd    <= 1'b0;
      free_fnd   <= 1'b0;
      best_fnd   <= 1'b0;
      have_prev  <= 1'b0;
      scan_cnt   <= '0;
      disp_cnt   <= '0;
    end else begin
      cmp_vld <= rd_en;
      cmp_idx <= rd_idx;

      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + SCAN_W'(1);
      end

      if (req_valid && req_ready) begin
        cmd_q     <= req.command;
        name_q    <= req.sym_name;
        key_q     <= req.sym_name[NAME_W-1 -: KEY_BITS];
        addr_q    <= ADDRESS_BITS'(req.sym_address);
        scan_cnt  <= '0;
        hit_fnd   <= 1'b0;
        free_fnd  <= 1'b0;
        best_fnd  <= 1'b0;
        have_prev <= 1'b0;
        disp_cnt  <= '0;
      end

      // compare stage, one slot per cycle behind the read
      if (cmp_vld) begin
        if (elem_valid && (rd_key == key_q) && !hit_fnd) begin
          hit_fnd  <= 1'b1;
          hit_idx  <= cmp_idx;
          hit_addr <= rd_addr;
        end
        if (!elem_valid && !free_fnd) begin
          free_fnd <= 1'b1;
          free_idx <= cmp_idx;
        end
        // smallest key above the one shown last
        if (elem_valid && (!have_prev || (rd_key > prev_key)) &&
            (!best_fnd || (rd_key < best_key))) begin
          best_fnd  <= 1'b1;
          best_key  <= rd_key;
          best_addr <= rd_addr;
        end
      end

      if (restart) begin
        scan_cnt  <= '0;
        hit_fnd   <= 1'b0;
        free_fnd  <= 1'b0;
        best_fnd  <= 1'b0;
        have_prev <= 1'b1;
        prev_key  <= best_key;
        disp_cnt  <= disp_cnt + OUT_CNT_W'(1);
      end

      if (emit) begin
        rsp       <= rsp_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (set_valid) begin
        slot_valid[free_idx] <= 1'b1;
        fill_cnt <= fill_cnt + SCAN_W'(1);
      end
      if (clr_valid) begin
        slot_valid[hit_idx] <= 1'b0;
        fill_cnt <= fill_cnt - SCAN_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_fill_cnt, clk, rst, int'(fill_cnt) == $countones(slot_valid), "fill count off")
  `ASSERT_ALWAYS(a_fill_range, clk, rst, int'(fill_cnt) <= TABLE_DEPTH, "fill count too big")
  `ASSERT_IMPLIES(a_free_ok, clk, rst, (state == S_DONE) && free_fnd, !slot_valid[free_idx], "slot busy")
  `ASSERT_NEXT(a_disp_rescan, clk, rst, emit && !rsp_next.last, state == S_SCAN, "no rescan")

endmodule

/* verif/testbench.sv */
// self-checking testbench for the symbol key value table
`timescale 1ns / 1ps

module testbench;
  import skvt_pkg::*;

  localparam logic [2:0]        CMD_RSVD_5  = 3'd5;
  localparam logic [2:0]        CMD_RSVD_6  = 3'd6;
  localparam logic [2:0]        CMD_RSVD_7  = 3'd7;
  localparam logic [NAME_W-1:0] KEY_MASK    = {NAME_W{1'b1}} << (8 * (8 - NAME_CHARS));
  localparam int                POOL_SIZE   = 24;
  localparam int                RAND_ITEMS  = 425;
  localparam int                TAIL_ITEMS  = 40;
  localparam int                HOLD_AT     = 150;
  localparam int                HOLD_CYCLES = 400;
  localparam int                DRAIN       = 100;
  localparam int                LIMIT       = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  symbol_key_value_table dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the table
  bit                    tbl_used [TABLE_DEPTH];
  logic [NAME_W-1:0]     tbl_key  [TABLE_DEPTH];
  logic [SYM_ADDR_W-1:0] tbl_addr [TABLE_DEPTH];

  req_t              cmd_q [$];
  rsp_t              reply_q [$];
  logic [NAME_W-1:0] name_pool [POOL_SIZE];

  int  total_cmds = 0;
  int  sent_cnt = 0;
  int  seen_cnt = 0;
  int  err_cnt = 0;
  int  cycle_cnt = 0;
  logic calm = 1'b0;

  int tx_gap = 0, tx_win = 0, tx_heat = 0;
  int rx_gap = 0, rx_win = 0, rx_heat = 0;
  int hold_cnt = 0;
  bit held = 1'b0;

  function automatic rsp_t make_reply(status_t s, logic [NAME_W-1:0] n,
                                      logic [SYM_ADDR_W-1:0] a, logic l);
    rsp_t o;
    o.status = s;
    o.out_name = n;
    o.out_address = a;
    o.last = l;
    return o;
  endfunction

  // apply one command to the shadow table and queue the replies it causes
  function automatic void table_apply(req_t r);
    logic [NAME_W-1:0] key;
    logic [NAME_W-1:0] prev;
    bit                have_prev;
    int                hit, best, free_slot, n;
    rsp_t              listing [$];
    key = r.sym_name & KEY_MASK;
    hit = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && tbl_used[i] && tbl_key[i] == key) hit = i;
    case (r.command)
      CMD_INSERT: begin
        if (hit >= 0) begin
          reply_q.push_back(make_reply(STS_DUPLICATE, r.sym_name, '0, 1'b1));
        end else begin
          free_slot = -1;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (free_slot < 0 && !tbl_used[i]) free_slot = i;
          if (free_slot >= 0) begin
            tbl_used[free_slot] = 1'b1;
            tbl_key[free_slot] = key;
            tbl_addr[free_slot] = r.sym_address;
            reply_q.push_back(make_reply(STS_INSERTED, r.sym_name, '0, 1'b1));
          end else begin
            reply_q.push_back(make_reply(STS_FULL, r.sym_name, '0, 1'b1));
          end
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          tbl_used[hit] = 1'b0;
          reply_q.push_back(make_reply(STS_DELETED, r.sym_name, '0, 1'b1));
        end else begin
          reply_q.push_back(make_reply(STS_NOT_FOUND, r.sym_name, '0, 1'b1));
        end
      end
      CMD_DISPLAY: begin
        have_prev = 1'b0;
        prev = '0;
        n = 0;
        best = 0;
        while (n < MAX_OUT && best >= 0) begin
          best = -1;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_used[i] && !(have_prev && tbl_key[i] <= prev))
              if (best < 0 || tbl_key[i] < tbl_key[best]) best = i;
          end
          if (best >= 0) begin
            listing.push_back(make_reply(STS_ENTRY, tbl_key[best], tbl_addr[best], 1'b0));
            prev = tbl_key[best];
            have_prev = 1'b1;
            n++;
          end
        end
        if (listing.size() == 0) begin
          reply_q.push_back(make_reply(STS_EMPTY, '0, '0, 1'b1));
        end else begin
          listing[listing.size()-1].last = 1'b1;
          foreach (listing[k]) reply_q.push_back(listing[k]);
        end
      end
      CMD_SEARCH: begin
        if (hit >= 0)
          reply_q.push_back(make_reply(STS_FOUND, r.sym_name, tbl_addr[hit], 1'b1));
        else
          reply_q.push_back(make_reply(STS_NOT_FOUND, r.sym_name, '0, 1'b1));
      end
      CMD_MODIFY: begin
        if (hit >= 0) begin
          tbl_addr[hit] = r.sym_address;
          reply_q.push_back(make_reply(STS_MODIFIED, r.sym_name, '0, 1'b1));
        end else begin
          reply_q.push_back(make_reply(STS_NOT_FOUND, r.sym_name, '0, 1'b1));
        end
      end
      default: ;  // reserved commands leave the table alone
    endcase
  endfunction

  function automatic void check_result(rsp_t got);
    rsp_t want;
    seen_cnt++;
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got status %0d name %h addr %h last %0d",
               $time, got.status, got.out_name, got.out_address, got.last);
      err_cnt++;
      return;
    end
    want = reply_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      err_cnt++;
    end
    if (got.out_name !== want.out_name) begin
      $display("%0t: name expected %h got %h", $time, want.out_name, got.out_name);
      err_cnt++;
    end
    if (got.out_address !== want.out_address) begin
      $display("%0t: address expected %h got %h", $time, want.out_address, got.out_address);
      err_cnt++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
      err_cnt++;
    end
  endfunction

  // lower-case name of len characters, zero padded
  function automatic logic [NAME_W-1:0] word_name(int len);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < len; i++) n[NAME_W-1-8*i -: 8] = 8'($urandom_range(97, 122));
    return n;
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    return name_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic req_t make_cmd(logic [2:0] c, logic [NAME_W-1:0] n,
                                    logic [SYM_ADDR_W-1:0] a);
    req_t r;
    r.command = c;
    r.sym_name = n;
    r.sym_address = a;
    return r;
  endfunction

  // grow phases favor inserts, shrink phases favor deletes
  function automatic logic [2:0] pick_cmd(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (r < (grow ? 45 : 15)) return CMD_INSERT;
    if (r < 55)               return CMD_DELETE;
    if (r < 70)               return CMD_SEARCH;
    if (r < 85)               return CMD_MODIFY;
    if (r < 95)               return CMD_DISPLAY;
    case ($urandom_range(0, 2))
      0:       return CMD_RSVD_5;
      1:       return CMD_RSVD_6;
      default: return CMD_RSVD_7;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    logic fire;
    fire = req_valid && req_ready;
    if (!rst) begin
      if (fire) begin
        table_apply(req);
        sent_cnt++;
      end
      calm <= (cmd_q.size() < TAIL_ITEMS);
      if (tx_win == 0) begin
        tx_win = $urandom_range(40, 300);
        tx_heat = $urandom_range(0, 3);
      end else begin
        tx_win--;
      end
      if (req_valid && !fire) begin
        // hold the payload until transfer
      end else if (tx_gap > 0) begin
        tx_gap--;
        req_valid <= 1'b0;
      end else if (cmd_q.size() != 0 && !calm && $urandom_range(0, 7) < tx_heat) begin
        tx_gap = $urandom_range(0, 12);
        req_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        req <= cmd_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) check_result(rsp);
      if (rx_win == 0) begin
        rx_win = $urandom_range(40, 300);
        rx_heat = $urandom_range(0, 3);
      end else begin
        rx_win--;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ready <= 1'b0;
      end else if (!held && seen_cnt >= HOLD_AT) begin
        // long back-pressure so the table backs up into its input
        held = 1'b1;
        hold_cnt = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) < rx_heat) begin
        rx_gap = $urandom_range(0, 12);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int                real_cnt;
    logic [2:0]        c;
    logic [NAME_W-1:0] ones;
    ones = {NAME_W{1'b1}};
    name_pool[0] = '0;
    name_pool[1] = ones;
    name_pool[2] = {$urandom, $urandom};
    name_pool[3] = {$urandom, $urandom};
    for (int i = 4; i < POOL_SIZE; i++) name_pool[i] = word_name($urandom_range(1, 8));

    // directed: empty table, extremes, every command, full table
    cmd_q.push_back(make_cmd(CMD_DISPLAY, '0, '0));
    cmd_q.push_back(make_cmd(CMD_SEARCH, name_pool[5], '0));
    cmd_q.push_back(make_cmd(CMD_DELETE, name_pool[6], 16'h1234));
    cmd_q.push_back(make_cmd(CMD_MODIFY, name_pool[7], 16'h4321));
    cmd_q.push_back(make_cmd(CMD_INSERT, '0, '0));
    cmd_q.push_back(make_cmd(CMD_INSERT, ones, 16'hffff));
    cmd_q.push_back(make_cmd(CMD_INSERT, '0, 16'h5a5a));
    cmd_q.push_back(make_cmd(CMD_SEARCH, ones, '0));
    cmd_q.push_back(make_cmd(CMD_MODIFY, '0, 16'ha5a5));
    cmd_q.push_back(make_cmd(CMD_SEARCH, '0, 16'hffff));
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      cmd_q.push_back(make_cmd(CMD_INSERT, word_name(i % 8 + 1), 16'($urandom)));
    // absent name into a full table, then a present one
    cmd_q.push_back(make_cmd(CMD_INSERT, {$urandom, $urandom}, 16'($urandom)));
    cmd_q.push_back(make_cmd(CMD_INSERT, ones, 16'h0001));
    cmd_q.push_back(make_cmd(CMD_DISPLAY, ones, ones[15:0]));
    cmd_q.push_back(make_cmd(CMD_RSVD_5, '0, '0));
    cmd_q.push_back(make_cmd(CMD_RSVD_7, ones, 16'hffff));
    cmd_q.push_back(make_cmd(CMD_DELETE, '0, '0));

    real_cnt = 0;
    while (real_cnt < RAND_ITEMS) begin
      c = pick_cmd((real_cnt / 50) % 2 == 0);
      cmd_q.push_back(make_cmd(c, pick_name(), 16'($urandom)));
      if (c <= CMD_MODIFY) real_cnt++;
    end
    total_cmds = cmd_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (sent_cnt < total_cmds) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_cnt == 0 && reply_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
